### sv/p2a_pkg.sv
package p2a_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int BCOL_W     = $clog2(LINE_DEPTH);
  localparam int BROW_W     = ROW_W - 1;

  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;
  localparam logic [FW_W-1:0] FW_MIN   = 11'd2;
  localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] FH_MIN   = 13'd2;
  localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int PAIR_W = 9;
  localparam int SUM_W  = 10;
  localparam int CHAR_W = 7;

  // result queue between front and back; the front holds off while the
  // pixels already in its pipe could overrun the queue
  localparam int QUE_DEPTH  = 8;
  localparam int QUE_PTR_W  = $clog2(QUE_DEPTH);
  localparam int QUE_LVL_W  = $clog2(QUE_DEPTH + 1);
  localparam int PIPE_SLACK = 4;

  localparam int RAMP_LEN = 70;
  localparam int IDX_W    = $clog2(RAMP_LEN);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(RAMP_LEN - 1);

  // darkest first, brightest (space) last
  localparam logic [CHAR_W-1:0] RAMP [RAMP_LEN] = '{
    7'h24, 7'h40, 7'h42, 7'h25, 7'h38, 7'h26, 7'h57, 7'h4D, 7'h23, 7'h2A,
    7'h6F, 7'h61, 7'h68, 7'h6B, 7'h62, 7'h64, 7'h70, 7'h71, 7'h77, 7'h6D,
    7'h5A, 7'h4F, 7'h30, 7'h51, 7'h4C, 7'h43, 7'h4A, 7'h55, 7'h59, 7'h58,
    7'h7A, 7'h63, 7'h76, 7'h75, 7'h6E, 7'h78, 7'h72, 7'h6A, 7'h66, 7'h74,
    7'h2F, 7'h5C, 7'h7C, 7'h28, 7'h29, 7'h31, 7'h7B, 7'h7D, 7'h5B, 7'h5D,
    7'h3F, 7'h2D, 7'h5F, 7'h2B, 7'h7E, 7'h3C, 7'h3E, 7'h69, 7'h21, 7'h6C,
    7'h49, 7'h3B, 7'h3A, 7'h2C, 7'h22, 7'h5E, 7'h60, 7'h27, 7'h2E, 7'h20
  };

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LEFT,
    OP_TOP,
    OP_BOT
  } op_e;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [BCOL_W-1:0] bcol;
    logic [BROW_W-1:0] brow;
    logic              row_end;
  } blk_t;

endpackage

### sv/pixel_to_ascii_block_mapper.sv
// Pixel to ASCII block mapper.
// Input queue side: RGB pixels in raster order; a pixel is taken on a clock
// edge with push high and full low. Configuration: cfg_we_i writes
// cfg_data_i into frame_width (index 0) or frame_height (index 1) at once;
// write only while no request is in flight.
// Result queue side: while empty is low the oldest result (ramp character,
// block column/row, row end) is on the outputs; pop takes it.
// One result comes per 2x2 block, on its fourth pixel. That pixel's result
// passes the registers for gray weighting, 1/100 scale, line store read,
// result queue and output register before it is on the outputs.
// Throughput: one pixel per cycle while full is low, set by the single-port write and
// single-port read of the top-row pair-sum line store (512 x 9).
// When the receiver stalls, results collect in an 8-deep queue; full rises
// once 5 are waiting, covering the requests still in the pipe.
// Reset: position returns to (0,0), width 640, height 480, queues empty.
// The line store needs no clearing: each entry is written by the top row
// before the lower row reads it.
module pixel_to_ascii_block_mapper
  import p2a_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [CHAR_W-1:0]     char_code_o,
  output logic [BCOL_W-1:0]     block_col_o,
  output logic [BROW_W-1:0]     block_row_o,
  output logic                  row_end_o
);

  logic                 blk_vld;
  blk_t                 blk;
  blk_t                 q_head;
  logic                 q_nempty;
  logic                 q_pop;
  logic [QUE_LVL_W-1:0] q_level;

  p2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_level_i  (q_level),
    .blk_vld_o  (blk_vld),
    .blk_o      (blk)
  );

  p2a_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (blk_vld),
    .data_i   (blk),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .nempty_o (q_nempty),
    .level_o  (q_level)
  );

  p2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_nempty_i  (q_nempty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .char_code_o (char_code_o),
    .block_col_o (block_col_o),
    .block_row_o (block_row_o),
    .row_end_o   (row_end_o)
  );

endmodule

### sv/p2a_ram.sv
module p2a_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/p2a_front.sv
module p2a_front
  import p2a_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [QUE_LVL_W-1:0]  q_level_i,
  output logic                  blk_vld_o,
  output blk_t                  blk_o
);

  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;
  logic             in_frame;
  op_e              op0;
  logic [14:0]      wsum;
  logic             row_end0;

  // stage 1: weighted sum
  op_e               s1_op_q;
  logic [14:0]       s1_wsum_q;
  logic [BCOL_W-1:0] s1_bcol_q;
  logic [BROW_W-1:0] s1_brow_q;
  logic              s1_end_q;

  // stage 2: gray, line store access
  op_e               s2_op_q;
  logic [7:0]        s2_gray_q;
  logic [BCOL_W-1:0] s2_bcol_q;
  logic [BROW_W-1:0] s2_brow_q;
  logic              s2_end_q;
  logic [27:0]       gray_prod;
  logic [PAIR_W-1:0] pair;
  logic [7:0]        left_q, left_d;

  // stage 3: line data back, block sum
  logic              s3_vld_q;
  logic [PAIR_W-1:0] s3_pair_q;
  logic [BCOL_W-1:0] s3_bcol_q;
  logic [BROW_W-1:0] s3_brow_q;
  logic              s3_end_q;
  logic [PAIR_W-1:0] line_rdata;

  assign full_o = q_level_i > QUE_LVL_W'(QUE_DEPTH - PIPE_SLACK);
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[FW_W-1:0];
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[FH_W-1:0];
      end
    end
  end

  always_comb begin
    w_eff = frame_width_q;
    if (frame_width_q < FW_MIN) begin
      w_eff = FW_MIN;
    end else if (frame_width_q > FW_MAX) begin
      w_eff = FW_MAX;
    end
    h_eff = frame_height_q;
    if (frame_height_q < FH_MIN) begin
      h_eff = FH_MIN;
    end else if (frame_height_q > FH_MAX) begin
      h_eff = FH_MAX;
    end
  end

  // classify the pixel by its place in the 2x2 grid; odd last column/row drop out
  always_comb begin
    in_frame = ({1'b0, col_q} < {w_eff[FW_W-1:1], 1'b0})
            && ({1'b0, row_q} < {h_eff[FH_W-1:1], 1'b0});
    op0 = OP_NONE;
    if (in_frame) begin
      if (!col_q[0]) begin
        op0 = OP_LEFT;
      end else if (!row_q[0]) begin
        op0 = OP_TOP;
      end else begin
        op0 = OP_BOT;
      end
    end
    row_end0 = {1'b0, col_q[COL_W-1:1]} == (w_eff[FW_W-1:1] - 10'd1);
    wsum = 15'({7'd0, red_i} * 15'd30) + 15'({7'd0, green_i} * 15'd59)
         + 15'({7'd0, blue_i} * 15'd11);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ({1'b0, col_q} + 11'd1 >= w_eff) begin
        col_d = '0;
        if ({1'b0, row_q} + 13'd1 >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // floor(x/100) = (x*5243) >> 19 for x up to 25500
  assign gray_prod = {13'd0, s1_wsum_q} * 28'd5243;
  assign pair      = {1'b0, left_q} + {1'b0, s2_gray_q};

  always_comb begin
    left_d = left_q;
    if (s2_op_q == OP_LEFT) begin
      left_d = s2_gray_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      s1_op_q  <= OP_NONE;
      s2_op_q  <= OP_NONE;
      s3_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      s1_op_q  <= accept ? op0 : OP_NONE;
      s2_op_q  <= s1_op_q;
      s3_vld_q <= (s2_op_q == OP_BOT);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wsum_q <= wsum;
    s1_bcol_q <= col_q[COL_W-1:1];
    s1_brow_q <= row_q[ROW_W-1:1];
    s1_end_q  <= row_end0;
    s2_gray_q <= gray_prod[26:19];
    s2_bcol_q <= s1_bcol_q;
    s2_brow_q <= s1_brow_q;
    s2_end_q  <= s1_end_q;
    s3_pair_q <= pair;
    s3_bcol_q <= s2_bcol_q;
    s3_brow_q <= s2_brow_q;
    s3_end_q  <= s2_end_q;
  end

  p2a_ram #(
    .Width (PAIR_W),
    .Depth (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s2_op_q == OP_TOP),
    .waddr_i (s2_bcol_q),
    .wdata_i (pair),
    .re_i    (s2_op_q == OP_BOT),
    .raddr_i (s2_bcol_q),
    .rdata_o (line_rdata)
  );

  assign blk_vld_o     = s3_vld_q;
  assign blk_o.sum     = {1'b0, line_rdata} + {1'b0, s3_pair_q};
  assign blk_o.bcol    = s3_bcol_q;
  assign blk_o.brow    = s3_brow_q;
  assign blk_o.row_end = s3_end_q;

endmodule

### sv/p2a_fifo.sv
module p2a_fifo
  import p2a_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  blk_t                 data_i,
  input  logic                 pop_i,
  output blk_t                 head_o,
  output logic                 nempty_o,
  output logic [QUE_LVL_W-1:0] level_o
);

  blk_t                 slot_q [QUE_DEPTH];
  logic [QUE_PTR_W-1:0] wptr_q, rptr_q;
  logic [QUE_LVL_W-1:0] level_q, level_d;
  logic                 do_pop;

  assign nempty_o = level_q != '0;
  assign do_pop   = pop_i && nempty_o;
  assign head_o   = slot_q[rptr_q];
  assign level_o  = level_q;

  always_comb begin
    level_d = level_q;
    if (push_i && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

### sv/p2a_back.sv
module p2a_back
  import p2a_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_nempty_i,
  input  blk_t              q_head_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic [BCOL_W-1:0] block_col_o,
  output logic [BROW_W-1:0] block_row_o,
  output logic              row_end_o
);

  logic [7:0]        avg;
  logic [14:0]       scaled;
  logic [14:0]       quot;
  logic [IDX_W-1:0]  idx;
  logic              out_vld_q;
  logic [CHAR_W-1:0] char_q;
  logic [BCOL_W-1:0] bcol_q;
  logic [BROW_W-1:0] brow_q;
  logic              end_q;

  // index = min(69, floor(avg*70/255)); x/255 as (x + (x>>8) + 1) >> 8
  always_comb begin
    avg    = q_head_i.sum[SUM_W-1:2];
    scaled = 15'({7'd0, avg} * 15'd70);
    quot   = (scaled + (scaled >> 8) + 15'd1) >> 8;
    idx    = quot[IDX_W-1:0];
    if (idx > IDX_MAX) begin
      idx = IDX_MAX;
    end
  end

  assign q_pop_o = q_nempty_i && (!out_vld_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (q_pop_o) begin
      out_vld_q <= 1'b1;
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      char_q <= RAMP[idx];
      bcol_q <= q_head_i.bcol;
      brow_q <= q_head_i.brow;
      end_q  <= q_head_i.row_end;
    end
  end

  assign empty_o     = !out_vld_q;
  assign char_code_o = char_q;
  assign block_col_o = bcol_q;
  assign block_row_o = brow_q;
  assign row_end_o   = end_q;

endmodule

### sv/p2a_checker.sv
module p2a_checker
  import p2a_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [CHAR_W-1:0] char_code_o,
  input logic [BCOL_W-1:0] block_col_o,
  input logic [BROW_W-1:0] block_row_o,
  input logic              row_end_o
);

  // a held result must not change under a stall
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(char_code_o) && $stable(block_col_o)
                       && $stable(block_row_o) && $stable(row_end_o))
    else $error("result changed while stalled");

  // every character lies in the printable range that the ramp spans
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> char_code_o >= 7'd32 && char_code_o <= 7'd126)
    else $error("character out of ramp range");

  // output idle, and idle at the sample before, means the queue drained, so input is open
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && $past(empty) |-> !full)
    else $error("full while result side drained");

  // nothing waits right after reset
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty && !full)
    else $error("not idle after reset");

endmodule

bind pixel_to_ascii_block_mapper p2a_checker u_p2a_checker (.*);

### test/glyph_board_pkg.sv
package glyph_board_pkg;

  import p2a_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [BCOL_W-1:0] bcol;
    logic [BROW_W-1:0] brow;
    logic              row_end;
  } glyph_t;

  class glyph_board;
    logic [FW_W-1:0]   frame_w;
    logic [FH_W-1:0]   frame_h;
    logic [PAIR_W-1:0] top_pairs [LINE_DEPTH];
    logic [7:0]        left_gray;
    int unsigned       col;
    int unsigned       row;
    glyph_t            due [$];
    int unsigned       fails;
    int unsigned       shown;

    function new();
      frame_w   = FW_RESET;
      frame_h   = FH_RESET;
      left_gray = '0;
      col       = 0;
      row       = 0;
      fails     = 0;
      shown     = 0;
      foreach (top_pairs[i]) top_pairs[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) begin
        frame_w = data[FW_W-1:0];
      end else if (idx == REG_FRAME_HEIGHT) begin
        frame_h = data[FH_W-1:0];
      end
    endfunction

    function bit at_origin();
      return (col == 0) && (row == 0);
    endfunction

    // one accepted pixel request: update position and line store, queue a glyph
    // when it completes a 2x2 block
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned gray;
      int unsigned bc;
      int unsigned pair_v;
      int unsigned avg;
      int unsigned idx;
      bit          in_blocks;
      glyph_t      gl;
      w = frame_w;
      if (w < FW_MIN) w = FW_MIN;
      if (w > FW_MAX) w = FW_MAX;
      h = frame_h;
      if (h < FH_MIN) h = FH_MIN;
      if (h > FH_MAX) h = FH_MAX;
      gray = (30 * r + 59 * g + 11 * b) / 100;
      bc = col >> 1;
      in_blocks = (col < (w & ~32'd1)) && (row < (h & ~32'd1)) && (bc < LINE_DEPTH);
      if (in_blocks) begin
        if (col[0] == 1'b0) begin
          left_gray = gray[7:0];
        end else begin
          pair_v = left_gray + gray;
          if (row[0] == 1'b0) begin
            top_pairs[bc] = pair_v[PAIR_W-1:0];
          end else begin
            avg = (top_pairs[bc] + pair_v) >> 2;
            idx = (avg * RAMP_LEN) / 255;
            if (idx > RAMP_LEN - 1) idx = RAMP_LEN - 1;
            gl.ch      = RAMP[idx];
            gl.bcol    = bc[BCOL_W-1:0];
            gl.brow    = BROW_W'(row >> 1);
            gl.row_end = (bc == (w >> 1) - 1);
            due.push_back(gl);
          end
        end
      end
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t exp_g;
      if (due.size() == 0) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $display("unexpected glyph: char %h col %0d row %0d end %0d",
                   got.ch, got.bcol, got.brow, got.row_end);
        end
        return;
      end
      exp_g = due.pop_front();
      if (got.ch !== exp_g.ch || got.bcol !== exp_g.bcol || got.brow !== exp_g.brow ||
          got.row_end !== exp_g.row_end) begin
        fails++;
        if (shown < 10) begin
          shown++;
          $write("glyph mismatch: expected char %h col %0d row %0d end %0d,",
                 exp_g.ch, exp_g.bcol, exp_g.brow, exp_g.row_end);
          $display(" got char %h col %0d row %0d end %0d",
                   got.ch, got.bcol, got.brow, got.row_end);
        end
      end
    endfunction

    function void close_out();
      if (due.size() != 0) begin
        fails += due.size();
        $display("%0d glyphs never delivered", due.size());
      end
    endfunction
  endclass

endpackage

### test/pixel_to_ascii_block_mapper_tb.sv
module pixel_to_ascii_block_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import p2a_pkg::*;
  import glyph_board_pkg::*;

  localparam int ITEMS       = 540;
  localparam int WIDE_ITEMS  = 64;
  localparam int LONG_HOLD   = 240;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [7:0]            red_i;
  logic [7:0]            green_i;
  logic [7:0]            blue_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  empty;
  logic                  pop;
  logic [CHAR_W-1:0]     char_code_o;
  logic [BCOL_W-1:0]     block_col_o;
  logic [BROW_W-1:0]     block_row_o;
  logic                  row_end_o;

  glyph_board board = new();

  bit          calm;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          long_hold_req;
  bit          run_done;
  int unsigned stuck_cycles;

  pixel_to_ascii_block_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .block_col_o (block_col_o),
    .block_row_o (block_row_o),
    .row_end_o   (row_end_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [23:0] rand_pixel();
    logic [7:0] c [3];
    int unsigned mode;
    mode = $urandom_range(0, 7);
    foreach (c[i]) begin
      if (mode == 0) begin
        c[i] = 8'd0;
      end else if (mode == 1) begin
        c[i] = 8'd255;
      end else begin
        case ($urandom_range(0, 5))
          0:       c[i] = 8'd0;
          1:       c[i] = 8'd255;
          default: c[i] = 8'($urandom);
        endcase
      end
    end
    return {c[0], c[1], c[2]};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_DATA_W'(data);
    @(posedge clk_i);
    board.write_reg(idx, CFG_DATA_W'(data));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_pixel(input logic [23:0] px);
    @(negedge clk_i);
    push    = 1'b1;
    red_i   = px[23:16];
    green_i = px[15:8];
    blue_i  = px[7:0];
    do @(posedge clk_i); while (full);
    board.note_pixel(px[23:16], px[15:8], px[7:0]);
  endtask

  task automatic sender_gap(input int unsigned n);
    logic [23:0] noise;
    @(negedge clk_i);
    noise   = 24'($urandom);
    push    = 1'b0;
    red_i   = noise[23:16];
    green_i = noise[15:8];
    blue_i  = noise[7:0];
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) begin
      if (tx_idle_on && !calm && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 11));
      send_pixel(rand_pixel());
    end
  endtask

  // stop requesting, wait for every glyph, then let the pipe run dry
  task automatic settle();
    @(negedge clk_i);
    push = 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // shrink to 2x2 mid-frame and step to the frame origin, so that a new size
  // never reads a line entry left unwritten
  task automatic resync();
    settle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    while (!board.at_origin()) send_pixel(rand_pixel());
    settle();
  endtask

  // result side: random stall bursts, plus one long hold on demand
  initial begin
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        pop = 1'b0;
      end else if (rx_idle_on && !calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 11) - 1;
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      board.check_glyph(glyph_t'{char_code_o, block_col_o, block_row_o, row_end_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !run_done) begin
      if ((push && !full) || (pop && !empty)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned n;
    int unsigned w_val;
    int unsigned h_val;
    int          phase;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    pop           = 1'b0;
    calm          = 1'b0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b0;
    run_done      = 1'b0;
    stuck_cycles  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 4x4 frame: black block, white block (index clamps to the last ramp entry),
    // single primaries and odd mixes
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 4);
    send_pixel(24'h000000); send_pixel(24'h000000); send_pixel(24'hffffff); send_pixel(24'hffffff);
    send_pixel(24'h000000); send_pixel(24'h000000); send_pixel(24'hffffff); send_pixel(24'hffffff);
    send_pixel(24'hff0000); send_pixel(24'h00ff00); send_pixel(24'h0000ff); send_pixel(24'h808080);
    send_pixel(24'h00ff00); send_pixel(24'hff0000); send_pixel(24'h010203); send_pixel(24'hfefd7f);
    settle();

    // odd width and height: last column and last row give nothing
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    send_pixel(24'h6496c8); send_pixel(24'hc86432); send_pixel(24'h070707);
    send_pixel(24'h323c46); send_pixel(24'h505a64); send_pixel(24'hffffff);
    send_pixel(24'hffffff); send_pixel(24'h000000); send_pixel(24'h55aa55);
    settle();

    // both registers above range: clamped to the widest line, start of its top row
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 8191);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(WIDE_ITEMS);

    random_items = 0;
    phase = 0;
    while (random_items < ITEMS) begin
      calm = (random_items >= ITEMS * 4 / 5);
      resync();
      n = $urandom_range(16, 96);
      case (phase)
        0: begin w_val = 0;  h_val = 1;    end
        1: begin w_val = 1;  h_val = 0;    end
        2: begin w_val = 33; h_val = 4096; end
        3: begin w_val = 2;  h_val = 2;  n = 120; end
        default: begin
          w_val = ($urandom_range(0, 19) < 14) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 64);
          if ($urandom_range(0, 19) == 0) w_val = $urandom_range(0, 2047);
          h_val = ($urandom_range(0, 19) < 15) ? $urandom_range(0, 8)
                                                : $urandom_range(0, 8191);
        end
      endcase
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // receiver holds off while requests keep coming, so full must rise
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
      end
      send_random(n);
      random_items += n;
      phase++;
    end

    settle();
    run_done = 1'b1;
    board.close_out();
    if (board.fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### pixel_to_ascii_block_mapper.f
sv/p2a_pkg.sv
sv/p2a_ram.sv
sv/p2a_front.sv
sv/p2a_fifo.sv
sv/p2a_back.sv
sv/pixel_to_ascii_block_mapper.sv
sv/p2a_checker.sv
test/glyph_board_pkg.sv
test/pixel_to_ascii_block_mapper_tb.sv
